// ----- rtl/bisr_pkg.sv -----
`timescale 1ns / 1ps

package bisr_pkg;

  // register defaults
  localparam logic [31:0] MAGIC_RESET    = 32'h5445_4E4B;
  localparam logic [31:0] MAX_RESET      = 32'h0100_0000;
  localparam logic [31:0] BASE_RESET     = 32'h0400_0000;

  // header layout
  localparam int          HDR_LEN        = 12;
  localparam int          HDR_BITS       = 8 * HDR_LEN;
  localparam int          HDR_CNT_W      = 4;

  // address width default
  localparam int          ADDRESS_WIDTH_DEF = 32;

  // configuration port
  localparam int          CFG_ADDR_W     = 4;

  typedef enum logic [1:0] {
    REG_MAGIC = 2'd0,
    REG_MAX   = 2'd1,
    REG_BASE  = 2'd2
  } reg_idx_t;

  // reply status codes
  localparam logic [1:0]  ST_OK          = 2'd0;
  localparam logic [1:0]  ST_BAD_MAGIC   = 2'd1;
  localparam logic [1:0]  ST_BAD_LENGTH  = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_address;
    logic [7:0]  write_byte;
    logic [31:0] bytes_received;
    logic        reply_valid;
    logic [1:0]  reply_status;
    logic [31:0] reply_checksum;
    logic [31:0] entry_address;
    logic [31:0] image_length;
  } out_t;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [31:0] max_image_bytes;
    logic [31:0] load_base;
  } cfg_t;

endpackage

// ----- rtl/boot_image_stream_receiver_unit.sv -----
`timescale 1ns / 1ps
// An accepted request waits in the input register; its result, if any, is registered at out_.
// One request per cycle unless out_stall holds; the receiver state updates in a single pass.
// in_stall rises only when the input register is full and the result register is stalled.
// Reset (rst_n low, synchronous): receiver back to header phase, state cleared,
// configuration registers back to their defaults. No clearing pass is needed.

module boot_image_stream_receiver_unit
  import bisr_pkg::*;
#(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t        cfg_r;
  logic        s1_valid_r;
  in_t         s1_item_r;
  logic        out_valid_r;
  out_t        out_data_r;
  logic        adv;
  logic        step;
  logic        res_valid;
  out_t        res;
  reg_idx_t    reg_sel;
  logic        cfg_wr;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_magic  <= MAGIC_RESET;
      cfg_r.max_image_bytes <= MAX_RESET;
      cfg_r.load_base       <= BASE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_MAGIC: cfg_r.expected_magic  <= pwdata;
        REG_MAX:   cfg_r.max_image_bytes <= pwdata;
        REG_BASE:  cfg_r.load_base       <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAGIC: prdata = cfg_r.expected_magic;
      REG_MAX:   prdata = cfg_r.max_image_bytes;
      REG_BASE:  prdata = cfg_r.load_base;
      default:   prdata = '0;
    endcase
  end

  // pipeline advance: result register free or being drained
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign step     = s1_valid_r && adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  bisr_core #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/bisr_core.sv -----
`timescale 1ns / 1ps

module bisr_core
  import bisr_pkg::*;
#(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  in_t  item,
  input  cfg_t cfg,
  output logic res_valid,
  output out_t res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_IMAGE  = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // low address bits kept by the staging bus
  localparam logic [31:0] ADDR_MASK = (ADDRESS_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << ADDRESS_WIDTH) - 64'd1);

  phase_t                 phase_r, phase_nxt;
  logic [HDR_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [HDR_BITS-1:0]    hdr_r, hdr_nxt;
  logic [31:0]            len_r, len_nxt;
  logic [31:0]            entry_r, entry_nxt;
  logic [31:0]            off_r, off_nxt;
  logic [23:0]            word_r, word_nxt;
  logic [31:0]            sum_r, sum_nxt;

  logic [HDR_BITS-1:0]    hdr_full;
  logic [31:0]            hdr_magic, hdr_len, hdr_entry;
  logic [1:0]             lane;
  logic [31:0]            off_inc;
  logic [31:0]            addr_sum;

  // header bytes shift in from the top, first byte ends up lowest
  assign hdr_full  = {item.data_byte, hdr_r[HDR_BITS-1:8]};
  assign hdr_magic = hdr_full[31:0];
  assign hdr_len   = hdr_full[63:32];
  assign hdr_entry = hdr_full[95:64];

  assign lane      = off_r[1:0];
  assign off_inc   = off_r + 32'd1;
  assign addr_sum  = cfg.load_base + off_r;

  // per-request update
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    hdr_nxt   = hdr_r;
    len_nxt   = len_r;
    entry_nxt = entry_r;
    off_nxt   = off_r;
    word_nxt  = word_r;
    sum_nxt   = sum_r;
    res_valid = 1'b0;
    res       = '0;
    if (step) begin
      if (item.command) begin
        // new connection
        phase_nxt = PH_HEADER;
        cnt_nxt   = '0;
        len_nxt   = '0;
        entry_nxt = '0;
        off_nxt   = '0;
        word_nxt  = '0;
        sum_nxt   = '0;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            hdr_nxt = hdr_full;
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == HDR_CNT_W'(HDR_LEN - 1)) begin
              if (hdr_magic != cfg.expected_magic) begin
                phase_nxt        = PH_DONE;
                res_valid        = 1'b1;
                res.reply_valid  = 1'b1;
                res.reply_status = ST_BAD_MAGIC;
              end else begin
                len_nxt   = hdr_len;
                entry_nxt = hdr_entry;
                off_nxt   = '0;
                word_nxt  = '0;
                sum_nxt   = '0;
                if (hdr_len == 32'd0 || hdr_len >= cfg.max_image_bytes) begin
                  phase_nxt        = PH_DONE;
                  res_valid        = 1'b1;
                  res.reply_valid  = 1'b1;
                  res.reply_status = ST_BAD_LENGTH;
                end else begin
                  phase_nxt = PH_IMAGE;
                end
              end
            end
          end
          PH_IMAGE: begin
            // word assembly and checksum
            if (lane == 2'd3) begin
              sum_nxt  = sum_r + {item.data_byte, word_r};
              word_nxt = '0;
            end else begin
              word_nxt = word_r | ({16'd0, item.data_byte} << {lane, 3'b000});
            end
            off_nxt            = off_inc;
            res_valid          = 1'b1;
            res.write_valid    = 1'b1;
            res.write_address  = addr_sum & ADDR_MASK;
            res.write_byte     = item.data_byte;
            res.bytes_received = off_inc;
            if (off_inc == len_r) begin
              phase_nxt          = PH_DONE;
              res.reply_valid    = 1'b1;
              res.reply_status   = ST_OK;
              res.reply_checksum = sum_nxt;
              res.entry_address  = entry_r;
              res.image_length   = len_r;
            end
          end
          default: begin
            // done phase and unused code: bytes are dropped
          end
        endcase
      end
    end
  end

  // receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      len_r   <= '0;
      entry_r <= '0;
      off_r   <= '0;
      word_r  <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      entry_r <= entry_nxt;
      off_r   <= off_nxt;
      word_r  <= word_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // header bytes need no reset, all are written before use
  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

// ----- rtl/bisr_checker.sv -----
`timescale 1ns / 1ps

module bisr_checker
  import bisr_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data,
  input logic pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every result carries a write or a reply
  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.write_valid || out_data.reply_valid)
    else $error("empty result");

  // an error reply never writes and carries no checksum and no byte count
  a_err_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reply_valid && out_data.reply_status != ST_OK |->
      !out_data.write_valid && out_data.reply_checksum == 32'd0 &&
      out_data.bytes_received == 32'd0)
    else $error("error reply with write data");

  // an ok reply comes with the last write of the image
  a_ok_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reply_valid && out_data.reply_status == ST_OK |->
      out_data.write_valid && out_data.bytes_received == out_data.image_length)
    else $error("ok reply not on last byte");

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid && pready)
    else $error("result present after reset");

endmodule

bind boot_image_stream_receiver_unit bisr_checker u_bisr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);

// ----- bench/boot_image_stream_receiver_checker.sv -----
`timescale 1ns / 1ps

module boot_image_stream_receiver_checker
  import bisr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_t                  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output int                    fails,
  output int                    pending
);

  typedef enum logic [1:0] {
    RC_HDR  = 2'd0,
    RC_BODY = 2'd1,
    RC_END  = 2'd2
  } rcv_state_t;

  // configuration copy
  logic [31:0] magic_reg;
  logic [31:0] max_bytes_reg;
  logic [31:0] base_reg;

  // receiver state copy
  rcv_state_t  rcv_state;
  logic [3:0]  hdr_cnt;
  logic [7:0]  hdr_bytes [HDR_LEN];
  logic [31:0] len_held;
  logic [31:0] entry_held;
  logic [31:0] img_offset;
  logic [23:0] word_part;
  logic [31:0] img_sum;

  // writes and replies still owed by the block
  out_t        owed_outcomes [$];
  out_t        want;
  out_t        outcome;
  bit          produces;

  task report(input string msg);
    $display("%0t: %s", $realtime, msg);
    fails++;
  endtask

  task check_field(input string name, input logic [31:0] got, input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report($sformatf("%s mismatch: got %h, wanted %h", name, got, exp_val));
    end
  endtask

  task clear_receiver();
    rcv_state  = RC_HDR;
    hdr_cnt    = '0;
    for (int i = 0; i < HDR_LEN; i++) hdr_bytes[i] = '0;
    len_held   = '0;
    entry_held = '0;
    img_offset = '0;
    word_part  = '0;
    img_sum    = '0;
  endtask

  // one stream byte or new-connection request through the receiver
  task absorb_request(input in_t req, output bit has_result, output out_t res);
    logic [31:0] magic_word;
    logic [1:0]  lane;
    begin
      has_result = 1'b0;
      res        = '0;
      if (req.command) begin
        clear_receiver();
      end else if (rcv_state == RC_HDR) begin
        if (hdr_cnt >= HDR_LEN) hdr_cnt = '0;
        hdr_bytes[hdr_cnt] = req.data_byte;
        hdr_cnt++;
        if (hdr_cnt == HDR_LEN) begin
          magic_word = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
          if (magic_word != magic_reg) begin
            rcv_state        = RC_END;
            has_result       = 1'b1;
            res.reply_valid  = 1'b1;
            res.reply_status = ST_BAD_MAGIC;
          end else begin
            len_held   = {hdr_bytes[7], hdr_bytes[6], hdr_bytes[5], hdr_bytes[4]};
            entry_held = {hdr_bytes[11], hdr_bytes[10], hdr_bytes[9], hdr_bytes[8]};
            img_offset = '0;
            word_part  = '0;
            img_sum    = '0;
            if (len_held == 32'd0 || len_held >= max_bytes_reg) begin
              rcv_state        = RC_END;
              has_result       = 1'b1;
              res.reply_valid  = 1'b1;
              res.reply_status = ST_BAD_LENGTH;
            end else begin
              rcv_state = RC_BODY;
            end
          end
        end
      end else if (rcv_state == RC_BODY) begin
        lane = img_offset[1:0];
        res.write_address = base_reg + img_offset;
        // little-endian word assembly, only whole words reach the sum
        if (lane == 2'd3) begin
          img_sum   = img_sum + {req.data_byte, word_part};
          word_part = '0;
        end else begin
          word_part = word_part | (24'(req.data_byte) << (8 * lane));
        end
        img_offset++;
        has_result         = 1'b1;
        res.write_valid    = 1'b1;
        res.write_byte     = req.data_byte;
        res.bytes_received = img_offset;
        if (img_offset == len_held) begin
          rcv_state          = RC_END;
          res.reply_valid    = 1'b1;
          res.reply_status   = ST_OK;
          res.reply_checksum = img_sum;
          res.entry_address  = entry_held;
          res.image_length   = len_held;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      magic_reg     = MAGIC_RESET;
      max_bytes_reg = MAX_RESET;
      base_reg      = BASE_RESET;
      clear_receiver();
      owed_outcomes.delete();
    end else begin
      // results first, so a request taken at this edge cannot match here
      if (out_valid && !out_stall) begin
        if (owed_outcomes.size() == 0) begin
          report("result with nothing outstanding");
        end else begin
          want = owed_outcomes.pop_front();
          check_field("write_valid", 32'(out_data.write_valid), 32'(want.write_valid));
          check_field("write_address", out_data.write_address, want.write_address);
          check_field("write_byte", 32'(out_data.write_byte), 32'(want.write_byte));
          check_field("bytes_received", out_data.bytes_received, want.bytes_received);
          check_field("reply_valid", 32'(out_data.reply_valid), 32'(want.reply_valid));
          check_field("reply_status", 32'(out_data.reply_status), 32'(want.reply_status));
          check_field("reply_checksum", out_data.reply_checksum, want.reply_checksum);
          check_field("entry_address", out_data.entry_address, want.entry_address);
          check_field("image_length", out_data.image_length, want.image_length);
        end
      end
      if (in_valid && !in_stall) begin
        absorb_request(in_data, produces, outcome);
        if (produces) owed_outcomes.push_back(outcome);
      end
      // register writes seen on the configuration port
      if (psel && penable && pwrite && pready) begin
        unique case (reg_idx_t'(paddr[3:2]))
          REG_MAGIC: magic_reg     = pwdata;
          REG_MAX:   max_bytes_reg = pwdata;
          REG_BASE:  base_reg      = pwdata;
          default: ;
        endcase
      end
    end
    pending = owed_outcomes.size();
  end

endmodule

// ----- bench/boot_image_stream_receiver_unit_tb.sv -----
`timescale 1ns / 1ps

module boot_image_stream_receiver_unit_tb;
  import bisr_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int                    fails;
  int                    pending;
  int                    send_idle;
  int                    recv_idle;
  int                    hold_cycles;
  int                    sent;
  logic [31:0]           cur_magic;
  logic [31:0]           cur_max;

  boot_image_stream_receiver_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  boot_image_stream_receiver_checker checker_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .fails    (fails),
    .pending  (pending)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side: long hold-off when asked, else random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle);
    end
  end

  // safety net against a hung block
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task park();
    in_valid = 1'b0;
  endtask

  // offer one request, starting and ending at a falling edge
  task send(input logic cmd, input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_data.command   = cmd;
    in_data.data_byte = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task cfg_write(input reg_idx_t idx, input logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_MAGIC) cur_magic = value;
    if (idx == REG_MAX) cur_max = value;
  endtask

  // wait for every owed result, then let the pipeline run dry
  task settle();
    park();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // new connection followed by a full header
  task send_header(input logic [31:0] magic_word, input logic [31:0] length,
                   input logic [31:0] entry);
    logic [95:0] hdr;
    begin
      hdr = {entry, length, magic_word};
      send(1'b1, 8'($urandom_range(255)));
      for (int i = 0; i < HDR_LEN; i++) send(1'b0, hdr[8*i +: 8]);
    end
  endtask

  // mostly well-formed transfers, some broken ones and some noise
  task run_transfer();
    logic [31:0] magic_word;
    logic [31:0] length;
    int          pick;
    int          body;
    begin
      pick = $urandom_range(99);
      if (pick >= 82) begin
        repeat ($urandom_range(1, 8)) send($urandom_range(9) == 0, 8'($urandom_range(255)));
      end else begin
        magic_word = cur_magic;
        if ($urandom_range(9) == 0) magic_word = magic_word ^ (32'h1 << $urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 75) length = $urandom_range(1, 24);
        else if (pick < 83) length = 32'd0;
        else if (pick < 91) length = cur_max;
        else length = $urandom;
        send_header(magic_word, length, $urandom);
        body = (length > 40) ? $urandom_range(0, 40) : int'(length);
        if ($urandom_range(6) == 0) body = $urandom_range(0, body);
        else if ($urandom_range(6) == 0) body += $urandom_range(1, 3);
        repeat (body) send(1'b0, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    send_idle   = 0;
    recv_idle   = 0;
    hold_cycles = 0;
    sent        = 0;
    cur_magic   = MAGIC_RESET;
    cur_max     = MAX_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: good image with a trailing partial word and a late byte, then bad magic
    send_header(cur_magic, 32'd5, 32'hFFFF_FFFF);
    send(1'b0, 8'hFF);
    send(1'b0, 8'h00);
    send(1'b0, 8'hA5);
    send(1'b0, 8'h5A);
    send(1'b0, 8'h80);
    send(1'b0, 8'h7F);
    send_header(~cur_magic, 32'd4, 32'd0);
    settle();

    // small maximum with a base near the top of the address space
    cfg_write(REG_MAGIC, $urandom);
    cfg_write(REG_MAX, 32'd20);
    cfg_write(REG_BASE, 32'hFFFF_FFF0);
    send_idle = 27;
    recv_idle = 61;
    while (sent < 270) run_transfer();
    settle();

    // zero and one as maximum reject every length
    cfg_write(REG_MAX, 32'd0);
    send_header(cur_magic, 32'd3, $urandom);
    settle();
    cfg_write(REG_MAX, 32'd1);
    send_header(cur_magic, 32'd1, $urandom);
    settle();

    // widest settings
    cfg_write(REG_MAGIC, 32'hFFFF_FFFF);
    cfg_write(REG_MAX, 32'hFFFF_FFFF);
    cfg_write(REG_BASE, 32'h0000_0000);
    send_idle = 61;
    recv_idle = 27;
    while (sent < 520) run_transfer();
    settle();

    cfg_write(REG_MAGIC, 32'h0000_0000);
    cfg_write(REG_MAX, 32'd32);
    cfg_write(REG_BASE, $urandom);
    send_idle = 0;
    recv_idle = 0;
    while (sent < 640) run_transfer();
    park();
    // result side held off while a long image keeps coming
    hold_cycles = 80;
    send_header(cur_magic, 32'd30, $urandom);
    repeat (30) send(1'b0, 8'($urandom_range(255)));
    // sender waits for the block to drain completely
    park();
    while (pending != 0) @(negedge clk);
    while (sent < 740) run_transfer();
    settle();

    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bisr_pkg.sv
rtl/bisr_core.sv
rtl/boot_image_stream_receiver_unit.sv
rtl/bisr_checker.sv
bench/boot_image_stream_receiver_checker.sv
bench/boot_image_stream_receiver_unit_tb.sv
